>>> hdl/vbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbb_pkg
// Shared types and constants of the vertical box blur: register map,
// register reset values, control structs and the divide-by-window reciprocals.
// ----------------------------------------------------------------------------
package vbb_pkg;

    // register map (word index = paddr[3:2])
    localparam int          APB_ADDR_W = 4;
    localparam logic [1:0]  REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0]  REG_BLUR_RADIUS  = 2'd2;

    // register reset values
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [1:0]  BLUR_RADIUS_RST  = 2'd2;

    // tallest frame the row counter covers
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // mean = (sum * recip) >> RECIP_SHIFT, exact for sums up to 7*255
    localparam int          RECIP_SHIFT = 16;
    localparam int          RECIP_W     = 16;

    // raw configuration registers
    typedef struct packed {
        logic [11:0] frame_width;
        logic [12:0] frame_height;
        logic [1:0]  blur_radius;
    } cfg_t;

    // per-pixel job control handed from the line store stage to the window
    typedef struct packed {
        logic [1:0] radius;   // effective radius, 1..3
        logic [1:0] j_first;  // first output row, as rows above the current one
        logic [1:0] j_last;   // last output row, as rows above the current one
        logic [2:0] row_sat;  // current row index, saturated at the store depth
    } job_ctrl_t;

    // reciprocal of the window height 2*r+1
    function automatic logic [RECIP_W-1:0] recip(input logic [1:0] radius);
        logic [RECIP_W-1:0] val;
        case (radius)
            2'd2:    val = 16'd13108;
            2'd3:    val = 16'd9363;
            default: val = 16'd21846;
        endcase
        return val;
    endfunction

endpackage

>>> hdl/vbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old word.
// ----------------------------------------------------------------------------
module vbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/vbb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbb_regs
// APB register file for frame size and blur radius. Every write, to any
// address, restarts the frame position.
// ----------------------------------------------------------------------------
module vbb_regs
    import vbb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg,
    output logic                  restart
);

    cfg_t       cfg_reg;
    logic       wr_beat;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_beat = psel && penable && pwrite;
    assign restart = wr_beat;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
            cfg_reg.blur_radius  <= BLUR_RADIUS_RST;
        end else if (wr_beat) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[11:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[12:0];
                REG_BLUR_RADIUS:  cfg_reg.blur_radius  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = {20'd0, cfg_reg.frame_width};
            REG_FRAME_HEIGHT: prdata = {19'd0, cfg_reg.frame_height};
            REG_BLUR_RADIUS:  prdata = {30'd0, cfg_reg.blur_radius};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/vbb_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbb_window
// Column window sequencer: holds one pixel's column history, gives one output row
// per cycle unless m_tready stalls, sums the window taps, divides by window height.
// ----------------------------------------------------------------------------
module vbb_window
    import vbb_pkg::*;
#(
    parameter int MAX_RADIUS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load_valid,
    output logic                             load_ready,
    input  job_ctrl_t                        load_ctrl,
    input  logic [2*MAX_RADIUS:0][31:0]      hist,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,
    output logic                             m_tlast
);

    localparam int ROW_SLOTS = 2 * MAX_RADIUS;
    localparam int TAPS      = ROW_SLOTS + 1;
    localparam int NL        = TAPS + MAX_RADIUS;
    localparam int SUM_W     = $clog2(255 * TAPS + 1);
    localparam int KW        = $clog2(NL + ROW_SLOTS) + 1;
    localparam int HW        = $clog2(ROW_SLOTS + 1);
    localparam int DW        = $clog2(TAPS) + 1;
    localparam int PW        = SUM_W + RECIP_W;

    // job registers
    logic                 job_valid_reg;
    logic [NL-1:0][31:0]  line_reg;
    logic [NL-1:0][31:0]  line_next;
    logic [1:0]           radius_reg;
    logic [1:0]           j_reg;
    logic [1:0]           j_last_reg;

    // sum stage
    logic                 sum_valid_reg;
    logic [SUM_W-1:0]     sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]     sum_r_next, sum_g_next, sum_b_next;
    logic [7:0]           sum_alpha_reg, alpha_next;
    logic                 sum_last_reg;
    logic [1:0]           sum_radius_reg;

    // output stage
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 out_free, sum_free, emit, job_done;
    logic [PW-1:0]        prod_r, prod_g, prod_b;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign sum_free   = !sum_valid_reg || out_free;
    assign emit       = job_valid_reg && sum_free;
    assign job_done   = emit && (j_reg == j_last_reg);
    assign load_ready = !job_valid_reg || job_done;

    // history line for a new job: entry i is row j_first+r-i above, clamped
    always_comb begin
        logic signed [KW-1:0] k;
        for (int i = 0; i < NL; i++) begin
            k = $signed(KW'(load_ctrl.j_first)) + $signed(KW'(load_ctrl.radius))
                - $signed(KW'(i));
            if (k < 0) begin
                k = '0;
            end
            if (k > $signed(KW'(load_ctrl.row_sat))) begin
                k = $signed(KW'(load_ctrl.row_sat));
            end
            line_next[i] = hist[HW'(k)];
        end
    end

    // job state: load, then shift one row per output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (load_valid) begin
            job_valid_reg <= 1'b1;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid) begin
            line_reg   <= line_next;
            radius_reg <= load_ctrl.radius;
            j_reg      <= load_ctrl.j_first;
            j_last_reg <= load_ctrl.j_last;
        end else if (emit) begin
            for (int i = 0; i < NL - 1; i++) begin
                line_reg[i] <= line_reg[i+1];
            end
            j_reg <= j_reg - 2'd1;
        end
    end

    // window sums over the first 2r+1 taps, alpha from the center tap
    always_comb begin
        sum_r_next = '0;
        sum_g_next = '0;
        sum_b_next = '0;
        alpha_next = line_reg[0][31:24];
        for (int d = 0; d < TAPS; d++) begin
            if (DW'(d) <= DW'({radius_reg, 1'b0})) begin
                sum_r_next = sum_r_next + SUM_W'(line_reg[d][7:0]);
                sum_g_next = sum_g_next + SUM_W'(line_reg[d][15:8]);
                sum_b_next = sum_b_next + SUM_W'(line_reg[d][23:16]);
            end
        end
        for (int i = 1; i <= MAX_RADIUS; i++) begin
            if (radius_reg == 2'(i)) begin
                alpha_next = line_reg[i][31:24];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_free) begin
            sum_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            sum_r_reg      <= sum_r_next;
            sum_g_reg      <= sum_g_next;
            sum_b_reg      <= sum_b_next;
            sum_alpha_reg  <= alpha_next;
            sum_last_reg   <= (j_reg == j_last_reg);
            sum_radius_reg <= radius_reg;
        end
    end

    // divide by window height through the reciprocal
    assign prod_r = PW'(sum_r_reg) * PW'(recip(sum_radius_reg));
    assign prod_g = PW'(sum_g_reg) * PW'(recip(sum_radius_reg));
    assign prod_b = PW'(sum_b_reg) * PW'(recip(sum_radius_reg));

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && sum_valid_reg) begin
            m_tdata_reg <= {sum_alpha_reg,
                            prod_b[RECIP_SHIFT +: 8],
                            prod_g[RECIP_SHIFT +: 8],
                            prod_r[RECIP_SHIFT +: 8]};
            m_tlast_reg <= sum_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hdl/vertical_box_blur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_box_blur
// Vertical box blur of an RGBA raster stream with edge rows clamped.
// A result beat passes the line store stage, job, sum and output registers.
// Throughput: one pixel per cycle while the window takes jobs, set by the line
// store read-modify-write of one column word per cycle; a pixel of the last
// row flushes up to r+1 rows, one at a time, from the single window summing unit.
// Reset: synchronous, active low; clears counters and handshake valid flags.
// The line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module vertical_box_blur
    import vbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // red_in, green_in, blue_in, alpha_in
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                  m_tlast,   // last_of_run
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int ROW_SLOTS = 2 * MAX_RADIUS;
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int SW        = $clog2(ROW_SLOTS);
    localparam int WORD_W    = 32 * ROW_SLOTS;
    localparam int EW        = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

    cfg_t                        cfg;
    logic                        restart;

    logic [EW-1:0]               width_eff;
    logic [12:0]                 height_eff;
    logic [1:0]                  radius_eff;

    // frame position
    logic [AW-1:0]               x_reg;
    logic [11:0]                 y_reg;
    logic [SW-1:0]               slot_reg;
    logic                        last_col, last_row, s_accept;

    // line store stage
    logic                        s1_valid_reg;
    logic [31:0]                 s1_pix_reg;
    logic [AW-1:0]               s1_x_reg;
    logic [SW-1:0]               s1_slot_reg;
    logic                        s1_has_reg;
    job_ctrl_t                   s1_ctrl_reg;
    logic                        s1_fwd_reg;
    logic [WORD_W-1:0]           s1_fwd_word_reg;
    logic                        s1_move, win_ready;

    job_ctrl_t                   ctrl_next;
    logic                        has_next;

    logic [WORD_W-1:0]           ram_rd_data;
    logic [ROW_SLOTS-1:0][31:0]  col_word, merged;
    logic [ROW_SLOTS:0][31:0]    hist;

    vbb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // effective frame size and radius
    always_comb begin
        width_eff = EW'(cfg.frame_width);
        if (width_eff == '0) begin
            width_eff = EW'(1);
        end else if (width_eff > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end
        height_eff = cfg.frame_height;
        if (height_eff == 13'd0) begin
            height_eff = 13'd1;
        end else if (height_eff > MAX_HEIGHT) begin
            height_eff = MAX_HEIGHT;
        end
        radius_eff = cfg.blur_radius;
        if (radius_eff == 2'd0) begin
            radius_eff = 2'd1;
        end else if (radius_eff > 2'(MAX_RADIUS)) begin
            radius_eff = 2'(MAX_RADIUS);
        end
    end

    assign s_accept = s_tvalid && s_tready;
    assign last_col = (EW'(x_reg) == width_eff - EW'(1));
    assign last_row = ({1'b0, y_reg} + 13'd1 == height_eff);

    // column, row and store slot counters
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            x_reg    <= '0;
            y_reg    <= '0;
            slot_reg <= '0;
        end else if (s_accept) begin
            if (last_col) begin
                x_reg <= '0;
                if (last_row) begin
                    y_reg    <= '0;
                    slot_reg <= '0;
                end else begin
                    y_reg    <= y_reg + 12'd1;
                    slot_reg <= (slot_reg == SW'(ROW_SLOTS - 1)) ? '0 : slot_reg + SW'(1);
                end
            end else begin
                x_reg <= x_reg + AW'(1);
            end
        end
    end

    // output rows this pixel releases
    always_comb begin
        ctrl_next.radius  = radius_eff;
        ctrl_next.row_sat = (y_reg >= 12'(ROW_SLOTS)) ? 3'(ROW_SLOTS) : y_reg[2:0];
        ctrl_next.j_first = radius_eff;
        ctrl_next.j_last  = radius_eff;
        has_next          = 1'b1;
        if (last_row) begin
            ctrl_next.j_first = (y_reg >= 12'(radius_eff)) ? radius_eff : y_reg[1:0];
            ctrl_next.j_last  = 2'd0;
        end else if (y_reg < 12'(radius_eff)) begin
            has_next = 1'b0;
        end
    end

    // line store: one word per column holding all stored rows
    vbb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_move),
        .wr_addr (s1_x_reg),
        .wr_data (merged),
        .rd_en   (s_accept),
        .rd_addr (x_reg),
        .rd_data (ram_rd_data)
    );

    assign s1_move  = s1_valid_reg && (!s1_has_reg || win_ready);
    assign s_tready = !s1_valid_reg || s1_move;

    // stage register; forward a write-back that lands with this beat's read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg      <= s_tdata;
            s1_x_reg        <= x_reg;
            s1_slot_reg     <= slot_reg;
            s1_ctrl_reg     <= ctrl_next;
            s1_has_reg      <= has_next;
            s1_fwd_reg      <= s1_move && (s1_x_reg == x_reg);
            s1_fwd_word_reg <= merged;
        end
    end

    // merge the new pixel into its slot and unroll history by age
    always_comb begin
        logic [SW:0] t;
        col_word = s1_fwd_reg ? s1_fwd_word_reg : ram_rd_data;
        for (int i = 0; i < ROW_SLOTS; i++) begin
            merged[i] = (SW'(i) == s1_slot_reg) ? s1_pix_reg : col_word[i];
        end
        hist[0] = s1_pix_reg;
        for (int k = 1; k <= ROW_SLOTS; k++) begin
            t = (SW+1)'(s1_slot_reg) + (SW+1)'(ROW_SLOTS - k);
            if (t >= (SW+1)'(ROW_SLOTS)) begin
                t = t - (SW+1)'(ROW_SLOTS);
            end
            hist[k] = col_word[t[SW-1:0]];
        end
    end

    vbb_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (s1_valid_reg && s1_has_reg && win_ready),
        .load_ready (win_ready),
        .load_ctrl  (s1_ctrl_reg),
        .hist       (hist),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
